@@ rtl/rgba_blit_pkg.sv @@
package rgba_blit_pkg;

    localparam int CHAN_W    = 8;
    localparam int COORD_W   = 13;
    localparam int COUNT_W   = 12;
    localparam int ADDR_W    = 26;
    localparam int WORD_W    = 32;
    localparam int BE_W      = 4;
    localparam int FIELD_W   = 9;
    localparam int FORMAT_W  = 4 * FIELD_W;
    localparam int DIMREG_W  = 13;
    localparam int BPP_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = FORMAT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd7;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] red_in;
    } pix_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [WORD_W-1:0] pixel_word;
        logic [BE_W-1:0]   byte_enable;
    } result_t;

    typedef struct packed {
        logic [FORMAT_W-1:0] pixel_format;
        logic [DIMREG_W-1:0] screen_width;
        logic [DIMREG_W-1:0] screen_height;
        logic [BPP_W-1:0]    bytes_per_pixel;
        logic [COUNT_W-1:0]  origin_x;
        logic [COUNT_W-1:0]  origin_y;
        logic [DIMREG_W-1:0] image_width;
        logic [DIMREG_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        pix_in_t            pixel;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } q_entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } q_status_t;

    function automatic logic [WORD_W-1:0] pack_channel(
        input logic [CHAN_W-1:0]  value,
        input logic [FIELD_W-1:0] field
    );
        logic [3:0]        len;
        logic [CHAN_W-1:0] kept;
        logic [WORD_W-1:0] wide;
        len = field[3:0];
        if (len > 4'd8)
        begin
            len = 4'd8;
        end
        kept = value >> (4'd8 - len);
        wide = {24'b0, kept};
        if (len == 4'd0)
        begin
            pack_channel = '0;
        end
        else
        begin
            pack_channel = wide << field[8:4];
        end
    endfunction

    function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] bpp);
        if (bpp == 3'd0)
        begin
            clamp_bpp = 3'd1;
        end
        else if (bpp > 3'd4)
        begin
            clamp_bpp = 3'd4;
        end
        else
        begin
            clamp_bpp = bpp;
        end
    endfunction

endpackage

@@ rtl/rgba_image_blit_clip_pack_core.sv @@
// rgba image blit: clips source pixels to the screen and packs them for a framebuffer
// src channel: one rgba8888 pixel per request, in raster order of the source image;
// the block keeps its own column and row counters, wrapping at image_width by image_height
// dst channel: one request per visible pixel carrying byte address, packed little-endian
// pixel word and byte enables; clipped pixels produce nothing
// cfg port: cfg_write with cfg_index and cfg_data writes one register; only while idle
// throughput: one pixel per clock, sustained, src and dst both able to move every cycle
// dst_valid rises once an accepted visible pixel has passed the queue write, then the row
// times width multiply stage, then the output register
// the front takes pixels into a four entry queue; src_stall is high only while it is full
// when the receiver stalls, the output register holds its request, the back pipeline
// freezes and the queue fills; up to six pixels in flight before src_stall rises
// reset clears counters, queue and pipeline valids and restores the register defaults
// (screen and image 1 by 1, four bytes per pixel, origin zero, pixel format zero)
module rgba_image_blit_clip_pack_core #(
    parameter int MAX_SCREEN_DIM = 4096
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       src_valid,
    output logic                                       src_stall,
    input  rgba_blit_pkg::pix_in_t                     src_pixel,
    output logic                                       dst_valid,
    input  logic                                       dst_stall,
    output rgba_blit_pkg::result_t                     dst_result,
    input  logic                                       cfg_write,
    input  logic [rgba_blit_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rgba_blit_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int DIM_W = $clog2(MAX_SCREEN_DIM + 1);

    rgba_blit_pkg::cfg_t       cfg_reg, cfg_next;
    logic [DIM_W-1:0]          screen_w, screen_h;
    logic                      push, pop, head_valid;
    rgba_blit_pkg::q_entry_t   push_entry, head_entry;
    rgba_blit_pkg::q_status_t  q_stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                rgba_blit_pkg::CFG_PIXEL_FORMAT:
                    cfg_next.pixel_format = cfg_data;
                rgba_blit_pkg::CFG_SCREEN_WIDTH:
                    cfg_next.screen_width = cfg_data[12:0];
                rgba_blit_pkg::CFG_SCREEN_HEIGHT:
                    cfg_next.screen_height = cfg_data[12:0];
                rgba_blit_pkg::CFG_BYTES_PER_PIXEL:
                    cfg_next.bytes_per_pixel = cfg_data[2:0];
                rgba_blit_pkg::CFG_ORIGIN_X:
                    cfg_next.origin_x = cfg_data[11:0];
                rgba_blit_pkg::CFG_ORIGIN_Y:
                    cfg_next.origin_y = cfg_data[11:0];
                rgba_blit_pkg::CFG_IMAGE_WIDTH:
                    cfg_next.image_width = cfg_data[12:0];
                rgba_blit_pkg::CFG_IMAGE_HEIGHT:
                    cfg_next.image_height = cfg_data[12:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format    <= '0;
            cfg_reg.screen_width    <= 13'd1;
            cfg_reg.screen_height   <= 13'd1;
            cfg_reg.bytes_per_pixel <= 3'd4;
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_y        <= '0;
            cfg_reg.image_width     <= 13'd1;
            cfg_reg.image_height    <= 13'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // screen sizes above the supported maximum act as the maximum
    assign screen_w = (32'(cfg_reg.screen_width) > 32'(MAX_SCREEN_DIM))
                    ? DIM_W'(MAX_SCREEN_DIM) : DIM_W'(cfg_reg.screen_width);
    assign screen_h = (32'(cfg_reg.screen_height) > 32'(MAX_SCREEN_DIM))
                    ? DIM_W'(MAX_SCREEN_DIM) : DIM_W'(cfg_reg.screen_height);

    rgba_blit_front #(
        .DIM_W (DIM_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .screen_w   (screen_w),
        .screen_h   (screen_h),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_pixel  (src_pixel),
        .q_full     (q_stat.full),
        .push       (push),
        .push_entry (push_entry)
    );

    rgba_blit_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .status     (q_stat)
    );

    rgba_blit_back #(
        .DIM_W (DIM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .screen_w   (screen_w),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_result (dst_result)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(q_stat.count) <= rgba_blit_pkg::QUEUE_DEPTH)
        else $error("queue occupancy above depth");

    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_stat.full && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("queue count did not follow a push");

    a_be_shape: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (dst_result.byte_enable == 4'h1 || dst_result.byte_enable == 4'h3
                    || dst_result.byte_enable == 4'h7 || dst_result.byte_enable == 4'hf))
        else $error("byte enable not a low run of ones");

    a_word_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_result.byte_enable[3]) |-> (dst_result.pixel_word[31:24] == 8'h0))
        else $error("pixel word has data in a disabled byte");

endmodule

@@ rtl/rgba_blit_front.sv @@
module rgba_blit_front #(
    parameter int DIM_W = 13
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rgba_blit_pkg::cfg_t                 cfg,
    input  logic [DIM_W-1:0]                    screen_w,
    input  logic [DIM_W-1:0]                    screen_h,
    input  logic                                src_valid,
    output logic                                src_stall,
    input  rgba_blit_pkg::pix_in_t              src_pixel,
    input  logic                                q_full,
    output logic                                push,
    output rgba_blit_pkg::q_entry_t             push_entry
);

    logic [rgba_blit_pkg::COUNT_W-1:0] col_reg, col_next;
    logic [rgba_blit_pkg::COUNT_W-1:0] row_reg, row_next;
    logic [rgba_blit_pkg::COORD_W-1:0] col_inc, row_inc;
    logic [rgba_blit_pkg::COORD_W-1:0] pos_x, pos_y;
    logic                              visible;
    logic                              accept;

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    assign pos_x = {1'b0, cfg.origin_x} + {1'b0, col_reg};
    assign pos_y = {1'b0, cfg.origin_y} + {1'b0, row_reg};

    assign visible = (32'(pos_x) < 32'(screen_w)) && (32'(pos_y) < 32'(screen_h));
    assign push    = accept && visible;

    assign push_entry.pixel = src_pixel;
    assign push_entry.pos_x = pos_x;
    assign push_entry.pos_y = pos_y;

    // counters step for every pixel, clipped or not
    always_comb
    begin
        col_inc  = {1'b0, col_reg} + 13'd1;
        row_inc  = {1'b0, row_reg} + 13'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= cfg.image_width || col_inc[12])
            begin
                col_next = '0;
                if (row_inc >= cfg.image_height || row_inc[12])
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_inc[11:0];
                end
            end
            else
            begin
                col_next = col_inc[11:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ rtl/rgba_blit_queue.sv @@
module rgba_blit_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  rgba_blit_pkg::q_entry_t    push_entry,
    input  logic                       pop,
    output logic                       head_valid,
    output rgba_blit_pkg::q_entry_t    head_entry,
    output rgba_blit_pkg::q_status_t   status
);

    rgba_blit_pkg::q_entry_t slots [rgba_blit_pkg::QUEUE_DEPTH];

    logic [rgba_blit_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rgba_blit_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rgba_blit_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                             do_push, do_pop;

    assign status.count = count_reg;
    assign status.full  = (count_reg == rgba_blit_pkg::QCNT_W'(rgba_blit_pkg::QUEUE_DEPTH));
    assign head_valid   = (count_reg != '0);
    assign head_entry   = slots[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/rgba_blit_back.sv @@
module rgba_blit_back #(
    parameter int DIM_W = 13
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rgba_blit_pkg::cfg_t        cfg,
    input  logic [DIM_W-1:0]           screen_w,
    input  logic                       head_valid,
    input  rgba_blit_pkg::q_entry_t    head_entry,
    output logic                       pop,
    output logic                       dst_valid,
    input  logic                       dst_stall,
    output rgba_blit_pkg::result_t     dst_result
);

    localparam int PROD_W = rgba_blit_pkg::COORD_W + DIM_W;

    // stage a: row times width, channel packing
    logic                                a_valid_reg, a_valid_next;
    logic [PROD_W-1:0]                   a_prod_reg;
    logic [rgba_blit_pkg::COORD_W-1:0]   a_x_reg;
    logic [rgba_blit_pkg::WORD_W-1:0]    a_word_reg;
    logic [rgba_blit_pkg::BE_W-1:0]      a_be_reg;
    logic [rgba_blit_pkg::BPP_W-1:0]     a_bpp_reg;

    logic                                out_valid_reg, out_valid_next;
    rgba_blit_pkg::result_t              out_reg;

    logic                                advance;
    logic                                load_a;
    logic [rgba_blit_pkg::BPP_W-1:0]     bpp;
    logic [rgba_blit_pkg::BE_W-1:0]      be;
    logic [rgba_blit_pkg::WORD_W-1:0]    mask;
    logic [rgba_blit_pkg::WORD_W-1:0]    word;
    logic [31:0]                         pos_sum;
    logic [rgba_blit_pkg::ADDR_W-1:0]    pos;
    logic [rgba_blit_pkg::ADDR_W-1:0]    addr;

    assign advance = !out_valid_reg || !dst_stall;
    assign load_a  = !a_valid_reg || advance;
    assign pop     = head_valid && load_a;

    assign bpp = rgba_blit_pkg::clamp_bpp(cfg.bytes_per_pixel);
    assign be  = 4'((5'd1 << bpp) - 5'd1);

    always_comb
    begin
        for (int i = 0; i < rgba_blit_pkg::BE_W; i++)
        begin
            mask[i*8 +: 8] = {8{be[i]}};
        end
        word = rgba_blit_pkg::pack_channel(head_entry.pixel.red_in,
                                           cfg.pixel_format[8:0])
             | rgba_blit_pkg::pack_channel(head_entry.pixel.green_in,
                                           cfg.pixel_format[17:9])
             | rgba_blit_pkg::pack_channel(head_entry.pixel.blue_in,
                                           cfg.pixel_format[26:18])
             | rgba_blit_pkg::pack_channel(head_entry.pixel.alpha_in,
                                           cfg.pixel_format[35:27]);
    end

    // stage b: add column, scale by bytes per pixel, wrap to address width
    assign pos_sum = 32'(a_prod_reg) + 32'(a_x_reg);
    assign pos     = pos_sum[rgba_blit_pkg::ADDR_W-1:0];
    assign addr    = pos * rgba_blit_pkg::ADDR_W'(a_bpp_reg);

    always_comb
    begin
        a_valid_next   = a_valid_reg;
        out_valid_next = out_valid_reg;
        if (load_a)
        begin
            a_valid_next = head_valid;
        end
        if (advance)
        begin
            out_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_prod_reg <= PROD_W'(head_entry.pos_y) * PROD_W'(screen_w);
            a_x_reg    <= head_entry.pos_x;
            a_word_reg <= word & mask;
            a_be_reg   <= be;
            a_bpp_reg  <= bpp;
        end
        if (advance && a_valid_reg)
        begin
            out_reg.byte_address <= addr;
            out_reg.pixel_word   <= a_word_reg;
            out_reg.byte_enable  <= a_be_reg;
        end
    end

    assign dst_valid  = out_valid_reg;
    assign dst_result = out_reg;

endmodule
